// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the delay search block.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define CCDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define CCDS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CCDS_ASSERT(lbl, prop, msg)
`define CCDS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/ccds_pkg.sv =====
// Package for the cross-correlation delay search: widths, beat types,
// and the command/status bundles between controller and datapath. No dependencies.
package ccds_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int ACC_W           = 44;
	localparam int LAG_OUT_W       = 11;
	localparam int MAX_SAMPLES_DEF = 4096;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] ref_sample;
		logic signed [SAMPLE_BITS-1:0] resp_sample;
		logic                          last;
	} ccds_in_t;

	typedef struct packed {
		logic [LAG_OUT_W-1:0] best_lag;
		logic [ACC_W-1:0]     best_corr;
		logic                 truncated;
	} ccds_out_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_vld;
		logic rd_last;
		logic load_out;
		logic truncated;
	} ccds_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} ccds_sts_t;

endpackage

// ===== rtl/ccds_ctrl.sv =====
// Controller of the delay search: load counter, lag and index sequencer.
// Depends on ccds_pkg.
module ccds_ctrl #(
	parameter int MAX_SAMPLES = ccds_pkg::MAX_SAMPLES_DEF,
	parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
	parameter int ADDR_W      = $clog2(MAX_SAMPLES),
	parameter int LAG_W       = CNT_W - 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_last,
	output logic                  sample_ready,
	input  ccds_pkg::ccds_sts_t   sts,
	output ccds_pkg::ccds_cmd_t   cmd,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [ADDR_W-1:0]     rd_addr_a,
	output logic [ADDR_W-1:0]     rd_addr_b,
	output logic [LAG_W-1:0]      lag
);
	import ccds_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              ovf_q, ovf_d;
	logic [LAG_W-1:0]  lag_q, lag_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              full;
	logic [CNT_W-1:0]  b_sum;
	logic              term_last;
	logic [LAG_W-1:0]  lag_end;

	assign full      = (count_q == CNT_W'(MAX_SAMPLES));
	assign b_sum     = CNT_W'(idx_q) + CNT_W'(lag_q);
	assign term_last = (b_sum == count_q - 1'b1);
	assign lag_end   = count_q[CNT_W-1:1] - 1'b1;

	assign wr_addr   = count_q[ADDR_W-1:0];
	assign rd_addr_a = idx_q;
	assign rd_addr_b = b_sum[ADDR_W-1:0];
	assign lag       = lag_q;

	always_comb begin
		cmd           = '0;
		cmd.truncated = ovf_q;
		sample_ready  = 1'b0;
		state_d       = state_q;
		count_d       = count_q;
		ovf_d         = ovf_q;
		lag_d         = lag_q;
		idx_d         = idx_q;
		unique case (state_q)
			ST_LOAD: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					if (!full) begin
						cmd.wr_en = 1'b1;
						count_d   = count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (sample_last) begin
						cmd.start = 1'b1;
						lag_d     = '0;
						idx_d     = '0;
						if (count_d[CNT_W-1:1] == '0) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_RUN;
						end
					end
				end
			end
			ST_RUN: begin
				cmd.rd_vld  = 1'b1;
				cmd.rd_last = term_last;
				if (term_last) begin
					idx_d = '0;
					if (lag_q == lag_end) begin
						state_d = ST_DRAIN;
					end else begin
						lag_d = lag_q + 1'b1;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					count_d      = '0;
					ovf_d        = 1'b0;
					state_d      = ST_LOAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			lag_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			lag_q   <= lag_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ===== rtl/ccds_dp.sv =====
// Datapath of the delay search: sample stores, multiply-accumulate pipe,
// best-lag tracking and result register. Depends on ccds_pkg.
module ccds_dp #(
	parameter int MAX_SAMPLES = ccds_pkg::MAX_SAMPLES_DEF,
	parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
	parameter int ADDR_W      = $clog2(MAX_SAMPLES),
	parameter int LAG_W       = CNT_W - 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccds_pkg::ccds_cmd_t   cmd,
	input  ccds_pkg::ccds_in_t    sample,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [ADDR_W-1:0]     rd_addr_a,
	input  logic [ADDR_W-1:0]     rd_addr_b,
	input  logic [LAG_W-1:0]      lag,
	input  logic                  result_ready,
	output logic                  result_valid,
	output ccds_pkg::ccds_out_t   result,
	output ccds_pkg::ccds_sts_t   sts
);
	import ccds_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_BITS;

	logic signed [SAMPLE_BITS-1:0] ref_mem  [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] resp_mem [MAX_SAMPLES];

	logic signed [SAMPLE_BITS-1:0] ref_rd_s1, resp_rd_s1;
	logic                          vld_s1, last_s1;
	logic [LAG_W-1:0]              lag_s1;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          vld_s2, last_s2;
	logic [LAG_W-1:0]              lag_s2;

	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  best_corr_q;
	logic [LAG_W-1:0]  best_lag_q;
	logic [ACC_W-1:0]  acc_sum;
	logic              better;
	ccds_out_t         result_q;
	logic              result_valid_q;

	// Sample stores: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			ref_mem[wr_addr]  <= sample.ref_sample;
			resp_mem[wr_addr] <= sample.resp_sample;
		end
	end

	always_ff @(posedge clk) begin
		ref_rd_s1  <= ref_mem[rd_addr_a];
		resp_rd_s1 <= resp_mem[rd_addr_b];
		lag_s1     <= lag;
		prod_s2    <= ref_rd_s1 * resp_rd_s1;
		lag_s2     <= lag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= cmd.rd_vld;
			last_s1 <= cmd.rd_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	assign acc_sum = acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign better  = $signed(acc_sum) > $signed(best_corr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			best_corr_q <= '0;
			best_lag_q  <= '0;
		end else if (cmd.start) begin
			acc_q       <= '0;
			best_corr_q <= '0;
			best_lag_q  <= '0;
		end else if (vld_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				if (better) begin
					best_corr_q <= acc_sum;
					best_lag_q  <= lag_s2;
				end
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.best_lag  <= LAG_OUT_W'(best_lag_q);
			result_q.best_corr <= best_corr_q;
			result_q.truncated <= cmd.truncated;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result        = result_q;
	assign result_valid  = result_valid_q;
	assign sts.pipe_busy = vld_s1 | vld_s2;
	assign sts.out_free  = !result_valid_q || result_ready;

endmodule

// ===== rtl/cross_correlation_delay_search.sv =====
// Loading takes one sample beat per cycle. After the beat marked last the search runs
// one product per cycle over every lag, then drains the pipe and loads the result before
// the result beat is offered; under two pairs it skips to the load. No beats are taken
// from the last beat until the result is loaded, which waits while an earlier result is
// still held. arst_n clears the counters, flags, best sum and result valid; the sample
// stores are not cleared.
`include "assert_macros.svh"

module cross_correlation_delay_search #(
	parameter int MAX_SAMPLES = ccds_pkg::MAX_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  ccds_pkg::ccds_in_t  sample,
	output logic                result_valid,
	input  logic                result_ready,
	output ccds_pkg::ccds_out_t result
);
	import ccds_pkg::*;

	// Pair count holds 0..MAX_SAMPLES; lags run below half of it.
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int LAG_W  = CNT_W - 1;

	ccds_cmd_t         cmd;
	ccds_sts_t         sts;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [LAG_W-1:0]  lag;

	// Sequence the load, the lag/index sweep, the drain and the result hand-off.
	ccds_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.CNT_W       (CNT_W),
		.ADDR_W      (ADDR_W),
		.LAG_W       (LAG_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_last  (sample.last),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.lag          (lag)
	);

	// Stores, read -> multiply -> accumulate pipe, best tracking, result register.
	ccds_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.CNT_W       (CNT_W),
		.ADDR_W      (ADDR_W),
		.LAG_W       (LAG_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (sample),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.lag          (lag),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.sts          (sts)
	);

	// Loading and the search sweep never overlap.
	`CCDS_NEVER(a_no_load_in_search, sample_ready && cmd.rd_vld, "beat taken during search")
	// The pipe is empty whenever a new record may start.
	`CCDS_NEVER(a_pipe_idle_on_load, sample_ready && sts.pipe_busy, "pipe busy while loading")
	// A result is only loaded into a free output register.
	`CCDS_ASSERT(a_load_when_free, cmd.load_out |-> sts.out_free, "result overwritten")
	// A loaded result is offered on the next cycle.
	`CCDS_ASSERT(a_load_shows, cmd.load_out |=> result_valid, "loaded result not offered")

endmodule
